@@ rtl/core/q16_16_fixed_point_alu_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Q16.16 ALU assertion macros
// Shared concurrent assertion forms for the Q16.16 arithmetic unit.
// ---------------------------------------------------------------------------
`ifndef Q16_16_FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define Q16_16_FIXED_POINT_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QALU_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("qalu same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QALU_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("qalu next-cycle check failed");

`endif

@@ rtl/core/qalu_pkg.sv @@
// ---------------------------------------------------------------------------
// Q16.16 ALU package
// Item types, operation codes, microcode format and the microprogram ROM.
// ---------------------------------------------------------------------------
package qalu_pkg;

    typedef struct packed {
        logic [4:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
    } alu_cmd_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
    } alu_res_t;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_NEG = 5'd2, OP_ABS = 5'd3,
        OP_MUL = 5'd4, OP_DIV = 5'd5, OP_EQ = 5'd6, OP_LT = 5'd7,
        OP_LE = 5'd8, OP_GT = 5'd9, OP_GE = 5'd10, OP_FROM_INT = 5'd11,
        OP_TO_INT = 5'd12, OP_TO_INT_ROUND = 5'd13, OP_SQRT = 5'd14,
        OP_RECIP = 5'd15, OP_FLOOR = 5'd16, OP_CEIL = 5'd17, OP_ROUND = 5'd18,
        OP_MIN = 5'd19, OP_MAX = 5'd20, OP_CLAMP = 5'd21, OP_LERP = 5'd22,
        OP_SIN = 5'd23, OP_COS = 5'd24, OP_TAN = 5'd25
    } op_code_t;

    localparam logic [31:0] FX_ZERO   = 32'h0000_0000;
    localparam logic [31:0] FX_ONE    = 32'h0001_0000;
    localparam logic [31:0] FX_HALF   = 32'h0000_8000;
    localparam logic [31:0] FX_TWO    = 32'h0002_0000;
    localparam logic [31:0] FX_PI     = 32'h0003_243F;
    localparam logic [31:0] FX_NEG_PI = 32'hFFFC_DBC1;
    localparam logic [31:0] FX_TWO_PI = 32'h0006_487E;
    localparam logic [31:0] FX_DIV0   = 32'h7FFF_FFFF;
    // Taylor coefficients 1/k, as the unit's own divide would give them.
    localparam logic [31:0] FX_K6     = 32'(65536 / 6);
    localparam logic [31:0] FX_K120   = 32'(65536 / 120);
    localparam logic [31:0] FX_K5040  = 32'(65536 / 5040);
    localparam logic [31:0] FX_K24    = 32'(65536 / 24);
    localparam logic [31:0] FX_K720   = 32'(65536 / 720);

    localparam int UPC_W = 7;
    localparam int DIV_STEPS = 48;

    typedef enum logic [3:0] {
        UO_NOP, UO_MOV, UO_ADD, UO_SUB, UO_HALF, UO_MULA, UO_MULW,
        UO_DIV, UO_SIMPLE, UO_SQSEED, UO_RCSEED
    } uop_t;

    typedef enum logic [2:0] {
        D_A, D_B, D_C, D_X, D_G, D_T, D_U, D_NONE
    } dst_t;

    typedef enum logic [4:0] {
        S_A, S_B, S_C, S_X, S_G, S_T, S_U,
        S_ZERO, S_ONE, S_TWO, S_HALF, S_PI, S_NPI, S_TWOPI, S_DIV0,
        S_K6, S_K120, S_K5040, S_K24, S_K720
    } src_t;

    typedef enum logic [2:0] {
        JC_NONE, JC_JMP, JC_EQ, JC_GE, JC_CN, JC_CR, JC_CALL, JC_RET
    } jcond_t;

    typedef struct packed {
        uop_t             op;
        dst_t             rd;
        src_t             s1;
        src_t             s2;
        jcond_t           cond;
        logic [UPC_W-1:0] tgt;
        logic             fin;
        logic             clr;
        logic             inc;
    } uword_t;

    typedef struct packed {
        logic [31:0] value;
        logic        flag;
    } simple_t;

    // Microprogram entry points and labels.
    localparam logic [UPC_W-1:0] UA_SIMPLE  = 7'd0;
    localparam logic [UPC_W-1:0] UA_MUL     = 7'd1;
    localparam logic [UPC_W-1:0] UA_DIV     = 7'd3;
    localparam logic [UPC_W-1:0] UA_LERP    = 7'd4;
    localparam logic [UPC_W-1:0] UA_SQRT    = 7'd8;
    localparam logic [UPC_W-1:0] UA_SQ_LOOP = 7'd10;
    localparam logic [UPC_W-1:0] UA_SQ_FIN  = 7'd15;
    localparam logic [UPC_W-1:0] UA_SQ_ZERO = 7'd16;
    localparam logic [UPC_W-1:0] UA_RECIP   = 7'd17;
    localparam logic [UPC_W-1:0] UA_RC_LOOP = 7'd19;
    localparam logic [UPC_W-1:0] UA_RC_FIN  = 7'd27;
    localparam logic [UPC_W-1:0] UA_RC_DZ   = 7'd28;
    localparam logic [UPC_W-1:0] UA_SIN     = 7'd29;
    localparam logic [UPC_W-1:0] UA_COS     = 7'd32;
    localparam logic [UPC_W-1:0] UA_TAN     = 7'd35;
    localparam logic [UPC_W-1:0] UA_RED     = 7'd40;
    localparam logic [UPC_W-1:0] UA_RD_L1   = 7'd41;
    localparam logic [UPC_W-1:0] UA_RD_P2   = 7'd44;
    localparam logic [UPC_W-1:0] UA_RD_L2   = 7'd45;
    localparam logic [UPC_W-1:0] UA_RD_RET  = 7'd48;
    localparam logic [UPC_W-1:0] UA_SINB    = 7'd49;
    localparam logic [UPC_W-1:0] UA_COSB    = 7'd66;

    function automatic logic fx_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] fx_abs(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic uword_t uw(input uop_t op, input dst_t rd, input src_t s1,
                                  input src_t s2, input jcond_t cond,
                                  input logic [UPC_W-1:0] tgt, input int fin,
                                  input int clr, input int inc);
        uword_t w;
        w.op = op;
        w.rd = rd;
        w.s1 = s1;
        w.s2 = s2;
        w.cond = cond;
        w.tgt = tgt;
        w.fin = fin[0];
        w.clr = clr[0];
        w.inc = inc[0];
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry_addr(input logic [4:0] op);
        logic [UPC_W-1:0] a;
        unique case (op)
            OP_MUL:   a = UA_MUL;
            OP_DIV:   a = UA_DIV;
            OP_LERP:  a = UA_LERP;
            OP_SQRT:  a = UA_SQRT;
            OP_RECIP: a = UA_RECIP;
            OP_SIN:   a = UA_SIN;
            OP_COS:   a = UA_COS;
            OP_TAN:   a = UA_TAN;
            default:  a = UA_SIMPLE;
        endcase
        return a;
    endfunction

    // The microprogram. Registers: A, B, C operands, X reduced angle,
    // G guess, T and U scratch. MULA forms a product, MULW writes it.
    function automatic uword_t urom(input logic [UPC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            UA_SIMPLE:       w = uw(UO_SIMPLE, D_NONE, S_A, S_A, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_MUL:          w = uw(UO_MULA, D_NONE, S_A, S_B, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_MUL + 7'd1:   w = uw(UO_MULW, D_NONE, S_A, S_A, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_DIV:          w = uw(UO_DIV, D_NONE, S_A, S_B, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_LERP:         w = uw(UO_SUB, D_T, S_B, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_LERP + 7'd1:  w = uw(UO_MULA, D_NONE, S_T, S_C, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_LERP + 7'd2:  w = uw(UO_MULW, D_T, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_LERP + 7'd3:  w = uw(UO_ADD, D_NONE, S_A, S_T, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_SQRT:         w = uw(UO_NOP, D_NONE, S_ZERO, S_A, JC_GE, UA_SQ_ZERO, 0, 0, 0);
            UA_SQRT + 7'd1:  w = uw(UO_SQSEED, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 1, 0);
            UA_SQ_LOOP:      w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CN, UA_SQ_FIN, 0, 0, 0);
            UA_SQ_LOOP + 7'd1: w = uw(UO_DIV, D_T, S_A, S_G, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SQ_LOOP + 7'd2: w = uw(UO_HALF, D_U, S_G, S_T, JC_NONE, UA_SIMPLE, 0, 0, 1);
            UA_SQ_LOOP + 7'd3: w = uw(UO_NOP, D_NONE, S_U, S_G, JC_EQ, UA_SQ_FIN, 0, 0, 0);
            UA_SQ_LOOP + 7'd4: w = uw(UO_MOV, D_G, S_U, S_U, JC_JMP, UA_SQ_LOOP, 0, 0, 0);
            UA_SQ_FIN:       w = uw(UO_MOV, D_NONE, S_G, S_G, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_SQ_ZERO:      w = uw(UO_MOV, D_NONE, S_ZERO, S_ZERO, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_RECIP:        w = uw(UO_NOP, D_NONE, S_A, S_ZERO, JC_EQ, UA_RC_DZ, 0, 0, 0);
            UA_RECIP + 7'd1: w = uw(UO_RCSEED, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 1, 0);
            UA_RC_LOOP:      w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CN, UA_RC_FIN, 0, 0, 0);
            UA_RC_LOOP + 7'd1: w = uw(UO_MULA, D_NONE, S_A, S_G, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_RC_LOOP + 7'd2: w = uw(UO_MULW, D_T, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_RC_LOOP + 7'd3: w = uw(UO_SUB, D_T, S_TWO, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_RC_LOOP + 7'd4: w = uw(UO_MULA, D_NONE, S_G, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_RC_LOOP + 7'd5: w = uw(UO_MULW, D_U, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 1);
            UA_RC_LOOP + 7'd6: w = uw(UO_NOP, D_NONE, S_U, S_G, JC_EQ, UA_RC_FIN, 0, 0, 0);
            UA_RC_LOOP + 7'd7: w = uw(UO_MOV, D_G, S_U, S_U, JC_JMP, UA_RC_LOOP, 0, 0, 0);
            UA_RC_FIN:       w = uw(UO_MOV, D_NONE, S_G, S_G, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_RC_DZ:        w = uw(UO_MOV, D_NONE, S_DIV0, S_DIV0, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_SIN:          w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_RED, 0, 0, 0);
            UA_SIN + 7'd1:   w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_SINB, 0, 0, 0);
            UA_SIN + 7'd2:   w = uw(UO_MOV, D_NONE, S_C, S_C, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_COS:          w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_RED, 0, 0, 0);
            UA_COS + 7'd1:   w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_COSB, 0, 0, 0);
            UA_COS + 7'd2:   w = uw(UO_MOV, D_NONE, S_C, S_C, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_TAN:          w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_RED, 0, 0, 0);
            UA_TAN + 7'd1:   w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_SINB, 0, 0, 0);
            UA_TAN + 7'd2:   w = uw(UO_MOV, D_A, S_C, S_C, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_TAN + 7'd3:   w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CALL, UA_COSB, 0, 0, 0);
            UA_TAN + 7'd4:   w = uw(UO_DIV, D_NONE, S_A, S_C, JC_NONE, UA_SIMPLE, 1, 0, 0);
            UA_RED:          w = uw(UO_MOV, D_X, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 1, 0);
            UA_RD_L1:        w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CR, UA_RD_P2, 0, 0, 0);
            UA_RD_L1 + 7'd1: w = uw(UO_NOP, D_NONE, S_PI, S_X, JC_GE, UA_RD_P2, 0, 0, 0);
            UA_RD_L1 + 7'd2: w = uw(UO_SUB, D_X, S_X, S_TWOPI, JC_JMP, UA_RD_L1, 0, 0, 1);
            UA_RD_P2:        w = uw(UO_NOP, D_NONE, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 1, 0);
            UA_RD_L2:        w = uw(UO_NOP, D_NONE, S_A, S_A, JC_CR, UA_RD_RET, 0, 0, 0);
            UA_RD_L2 + 7'd1: w = uw(UO_NOP, D_NONE, S_X, S_NPI, JC_GE, UA_RD_RET, 0, 0, 0);
            UA_RD_L2 + 7'd2: w = uw(UO_ADD, D_X, S_X, S_TWOPI, JC_JMP, UA_RD_L2, 0, 0, 1);
            UA_RD_RET:       w = uw(UO_NOP, D_NONE, S_A, S_A, JC_RET, UA_SIMPLE, 0, 0, 0);
            UA_SINB:         w = uw(UO_MULA, D_NONE, S_X, S_X, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd1:  w = uw(UO_MULW, D_T, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd2:  w = uw(UO_MULA, D_NONE, S_T, S_X, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd3:  w = uw(UO_MULW, D_U, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd4:  w = uw(UO_MULA, D_NONE, S_U, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd5:  w = uw(UO_MULW, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd6:  w = uw(UO_MULA, D_NONE, S_G, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd7:  w = uw(UO_MULW, D_B, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd8:  w = uw(UO_MULA, D_NONE, S_U, S_K6, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd9:  w = uw(UO_MULW, D_U, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd10: w = uw(UO_SUB, D_C, S_X, S_U, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd11: w = uw(UO_MULA, D_NONE, S_G, S_K120, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd12: w = uw(UO_MULW, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd13: w = uw(UO_ADD, D_C, S_C, S_G, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd14: w = uw(UO_MULA, D_NONE, S_B, S_K5040, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd15: w = uw(UO_MULW, D_B, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_SINB + 7'd16: w = uw(UO_SUB, D_C, S_C, S_B, JC_RET, UA_SIMPLE, 0, 0, 0);
            UA_COSB:         w = uw(UO_MULA, D_NONE, S_X, S_X, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd1:  w = uw(UO_MULW, D_T, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd2:  w = uw(UO_MULA, D_NONE, S_T, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd3:  w = uw(UO_MULW, D_U, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd4:  w = uw(UO_MULA, D_NONE, S_U, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd5:  w = uw(UO_MULW, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd6:  w = uw(UO_MULA, D_NONE, S_T, S_HALF, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd7:  w = uw(UO_MULW, D_T, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd8:  w = uw(UO_SUB, D_C, S_ONE, S_T, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd9:  w = uw(UO_MULA, D_NONE, S_U, S_K24, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd10: w = uw(UO_MULW, D_U, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd11: w = uw(UO_ADD, D_C, S_C, S_U, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd12: w = uw(UO_MULA, D_NONE, S_G, S_K720, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd13: w = uw(UO_MULW, D_G, S_A, S_A, JC_NONE, UA_SIMPLE, 0, 0, 0);
            UA_COSB + 7'd14: w = uw(UO_SUB, D_C, S_C, S_G, JC_RET, UA_SIMPLE, 0, 0, 0);
            default:         w = uw(UO_NOP, D_NONE, S_A, S_A, JC_NONE, UA_SIMPLE, 1, 0, 0);
        endcase
        return w;
    endfunction

    // Single-step operations: add, compare, conversions, rounding, select.
    function automatic simple_t simple_op(input logic [4:0] op, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c);
        simple_t     s;
        logic [15:0] frac;
        logic [31:0] ipart;
        logic [31:0] sext;
        frac  = a[15:0];
        ipart = {a[31:16], 16'h0000};
        sext  = {{16{a[31]}}, a[31:16]};
        s.value = FX_ZERO;
        s.flag  = 1'b0;
        unique case (op)
            OP_ADD:          s.value = a + b;
            OP_SUB:          s.value = a - b;
            OP_NEG:          s.value = 32'd0 - a;
            OP_ABS:          s.value = fx_abs(a);
            OP_EQ:           s.flag = (a == b);
            OP_LT:           s.flag = fx_less(a, b);
            OP_LE:           s.flag = !fx_less(b, a);
            OP_GT:           s.flag = fx_less(b, a);
            OP_GE:           s.flag = !fx_less(a, b);
            OP_FROM_INT:     s.value = {a[15:0], 16'h0000};
            OP_TO_INT:       s.value = sext;
            OP_TO_INT_ROUND: s.value = sext + {31'd0, frac[15]};
            OP_FLOOR:        s.value = ipart - ((a[31] && frac != 16'd0) ? FX_ONE : FX_ZERO);
            OP_CEIL:         s.value = ipart + ((frac != 16'd0) ? FX_ONE : FX_ZERO);
            OP_ROUND:        s.value = ipart + (frac[15] ? FX_ONE : FX_ZERO);
            OP_MIN:          s.value = fx_less(a, b) ? a : b;
            OP_MAX:          s.value = fx_less(b, a) ? a : b;
            OP_CLAMP:        s.value = fx_less(a, b) ? b : (fx_less(c, a) ? c : a);
            default:         s.value = FX_ZERO;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/q16_16_fixed_point_alu_unit.sv @@
// ---------------------------------------------------------------------------
// Q16.16 fixed-point arithmetic unit
// Microcoded sequencer over a small register datapath with a registered
// multiplier and a bit-serial restoring divider.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// command   in         start high while busy low   cmd    (alu_cmd_t)
// result    out        done high for one cycle     result (alu_res_t)
//
// One item is worked on at a time. Divide runs 48 divider steps between
// load and write-back. Square root and reciprocal run Newton steps, and
// sine, cosine and tangent run 2*pi reduction steps up to the reduction
// limit; with the default limits the slowest item is a square root that
// runs all Newton steps. Reset clears the sequencer and the divider
// control; no clearing pass follows. The receiver cannot stall: each
// result is presented on done for exactly one cycle.
`include "q16_16_fixed_point_alu_unit_defines.svh"

module q16_16_fixed_point_alu_unit
    import qalu_pkg::*;
#(
    parameter int NEWTON_STEPS    = 8,
    parameter int REDUCTION_LIMIT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_cmd_t cmd,
    output logic     done,
    output alu_res_t result
);

    // The loop counter must hold the larger of the two iteration limits.
    localparam int CNT_MAX = (NEWTON_STEPS > REDUCTION_LIMIT) ? NEWTON_STEPS : REDUCTION_LIMIT;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [UPC_W-1:0] pc_reg, pc_next;
    logic [UPC_W-1:0] ret_reg, ret_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    alu_res_t         result_reg, result_next;
    logic [4:0]       op_reg;

    // Working registers of the datapath.
    logic [31:0] a_reg, b_reg, c_reg, x_reg, g_reg, t_reg, u_reg;

    // Multiplier output stage.
    logic [31:0] mprod_reg;
    logic        mneg_reg;

    // Divider state: partial remainder, dividend/quotient shift register.
    logic              div_run_reg, div_run_next;
    logic              div_fin_reg, div_fin_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [31:0]       rem_reg;
    logic [47:0]       nq_reg;
    logic [31:0]       den_reg;
    logic              dz_reg;
    logic              dneg_reg;

    uword_t      uw_cur;
    logic [31:0] s1v, s2v;
    logic [31:0] wval;
    logic        wflag;
    simple_t     simple_res;
    logic        accept;
    logic        running;
    logic        advance;
    logic        taken;
    logic        div_load;
    logic [32:0] rem_trial;
    logic        rem_ge;
    logic [31:0] sum12;
    logic [31:0] abs1, abs2;
    logic [63:0] prod;

    assign accept  = start && (state_reg == ST_IDLE);
    assign running = (state_reg == ST_RUN);
    assign uw_cur  = urom(pc_reg);

    // A divide word holds the sequencer until the divider has finished.
    assign advance  = running && ((uw_cur.op != UO_DIV) || div_fin_reg);
    assign div_load = running && (uw_cur.op == UO_DIV) && !div_run_reg && !div_fin_reg;

    function automatic logic [31:0] src_val(input src_t s, input logic [31:0] a,
                                            input logic [31:0] b, input logic [31:0] c,
                                            input logic [31:0] x, input logic [31:0] g,
                                            input logic [31:0] t, input logic [31:0] u);
        logic [31:0] v;
        unique case (s)
            S_A:     v = a;
            S_B:     v = b;
            S_C:     v = c;
            S_X:     v = x;
            S_G:     v = g;
            S_T:     v = t;
            S_U:     v = u;
            S_ZERO:  v = FX_ZERO;
            S_ONE:   v = FX_ONE;
            S_TWO:   v = FX_TWO;
            S_HALF:  v = FX_HALF;
            S_PI:    v = FX_PI;
            S_NPI:   v = FX_NEG_PI;
            S_TWOPI: v = FX_TWO_PI;
            S_DIV0:  v = FX_DIV0;
            S_K6:    v = FX_K6;
            S_K120:  v = FX_K120;
            S_K5040: v = FX_K5040;
            S_K24:   v = FX_K24;
            S_K720:  v = FX_K720;
            default: v = FX_ZERO;
        endcase
        return v;
    endfunction

    assign s1v = src_val(uw_cur.s1, a_reg, b_reg, c_reg, x_reg, g_reg, t_reg, u_reg);
    assign s2v = src_val(uw_cur.s2, a_reg, b_reg, c_reg, x_reg, g_reg, t_reg, u_reg);

    assign simple_res = simple_op(op_reg, a_reg, b_reg, c_reg);
    assign sum12      = s1v + s2v;
    assign abs1       = fx_abs(s1v);
    assign abs2       = fx_abs(s2v);
    assign prod       = {32'd0, abs1} * {32'd0, abs2};

    // Value that the current control word produces.
    always_comb
    begin
        wval  = FX_ZERO;
        wflag = 1'b0;
        unique case (uw_cur.op)
            UO_NOP:    wval = FX_ZERO;
            UO_MOV:    wval = s1v;
            UO_ADD:    wval = sum12;
            UO_SUB:    wval = s1v - s2v;
            UO_HALF:   wval = {sum12[31], sum12[31:1]};
            UO_MULA:   wval = FX_ZERO;
            UO_MULW:   wval = mneg_reg ? (32'd0 - mprod_reg) : mprod_reg;
            UO_DIV:    wval = dz_reg ? FX_DIV0
                                     : (dneg_reg ? (32'd0 - nq_reg[31:0]) : nq_reg[31:0]);
            UO_SIMPLE:
            begin
                wval  = simple_res.value;
                wflag = simple_res.flag;
            end
            UO_SQSEED: wval = (s1v >= FX_ONE) ? {1'b0, s1v[31:1]} : FX_HALF;
            UO_RCSEED:
            begin
                if (abs1[31])
                begin
                    wval = FX_TWO;
                end
                else if (abs1 >= FX_TWO)
                begin
                    wval = FX_HALF;
                end
                else if (abs1 >= FX_ONE)
                begin
                    wval = FX_ONE;
                end
                else
                begin
                    wval = FX_TWO;
                end
            end
            default:   wval = FX_ZERO;
        endcase
    end

    // Branch decision.
    always_comb
    begin
        unique case (uw_cur.cond)
            JC_NONE: taken = 1'b0;
            JC_JMP:  taken = 1'b1;
            JC_EQ:   taken = (s1v == s2v);
            JC_GE:   taken = !fx_less(s1v, s2v);
            JC_CN:   taken = (cnt_reg == CNT_W'(NEWTON_STEPS));
            JC_CR:   taken = (cnt_reg == CNT_W'(REDUCTION_LIMIT));
            JC_CALL: taken = 1'b1;
            JC_RET:  taken = 1'b1;
            default: taken = 1'b0;
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (accept)
        begin
            state_next = ST_RUN;
            pc_next    = entry_addr(cmd.operation);
        end
        else if (advance)
        begin
            if (uw_cur.clr)
            begin
                cnt_next = '0;
            end
            else if (uw_cur.inc)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (uw_cur.cond == JC_RET)
            begin
                pc_next = ret_reg;
            end
            else if (taken)
            begin
                pc_next = uw_cur.tgt;
            end
            else
            begin
                pc_next = pc_reg + UPC_W'(1);
            end
            if (uw_cur.cond == JC_CALL)
            begin
                ret_next = pc_reg + UPC_W'(1);
            end
            if (uw_cur.fin)
            begin
                state_next               = ST_IDLE;
                done_next                = 1'b1;
                result_next.result_value = wval;
                result_next.compare_true = wflag;
            end
        end
    end

    // Divider control and one restoring step.
    assign rem_trial = {rem_reg, nq_reg[47]};
    assign rem_ge    = (rem_trial >= {1'b0, den_reg});

    always_comb
    begin
        div_run_next = div_run_reg;
        div_fin_next = div_fin_reg;
        dcnt_next    = dcnt_reg;
        if (div_load)
        begin
            div_run_next = 1'b1;
            dcnt_next    = '0;
        end
        else if (div_run_reg)
        begin
            dcnt_next = dcnt_reg + DCNT_W'(1);
            if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                div_run_next = 1'b0;
                div_fin_next = 1'b1;
            end
        end
        else if (advance && div_fin_reg)
        begin
            div_fin_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= UA_SIMPLE;
            ret_reg     <= UA_SIMPLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            div_run_reg <= 1'b0;
            div_fin_reg <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            ret_reg     <= ret_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            div_run_reg <= div_run_next;
            div_fin_reg <= div_fin_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            op_reg <= cmd.operation;
            a_reg  <= cmd.operand_a;
            b_reg  <= cmd.operand_b;
            c_reg  <= cmd.operand_c;
        end
        else if (advance && (uw_cur.op != UO_NOP) && (uw_cur.op != UO_MULA))
        begin
            unique case (uw_cur.rd)
                D_A:     a_reg <= wval;
                D_B:     b_reg <= wval;
                D_C:     c_reg <= wval;
                D_X:     x_reg <= wval;
                D_G:     g_reg <= wval;
                D_T:     t_reg <= wval;
                D_U:     u_reg <= wval;
                D_NONE:  ;
                default: ;
            endcase
        end
        if (advance && (uw_cur.op == UO_MULA))
        begin
            mprod_reg <= prod[47:16];
            mneg_reg  <= s1v[31] ^ s2v[31];
        end
        if (div_load)
        begin
            rem_reg  <= 32'd0;
            nq_reg   <= {abs1, 16'h0000};
            den_reg  <= abs2;
            dz_reg   <= (s2v == 32'd0);
            dneg_reg <= s1v[31] ^ s2v[31];
        end
        else if (div_run_reg)
        begin
            rem_reg <= rem_ge ? 32'(rem_trial - {1'b0, den_reg}) : rem_trial[31:0];
            nq_reg  <= {nq_reg[46:0], rem_ge};
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `QALU_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `QALU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `QALU_ASSERT_IMPL(a_div_owner, clk, rst_n, div_run_reg, running && (uw_cur.op == UO_DIV))
    `QALU_ASSERT_NEXT(a_div_fin_once, clk, rst_n, div_fin_reg, !div_fin_reg)

endmodule
